@@ design/sine_wave_led_dither_pwm_macros.svh @@
// assertion macros used by the led dither pwm top level
// expects clk and rst_n in the scope of the module that uses them
`ifndef SINE_WAVE_LED_DITHER_PWM_MACROS_SVH
`define SINE_WAVE_LED_DITHER_PWM_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SWLD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SWLD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/swld_pkg.sv @@
// types, constants and the quarter-wave sine table of the led dither pwm block
// no dependencies
package swld_pkg;

  localparam int POT_W    = 10;
  localparam int SPREAD_W = 8;
  localparam int ANGLE_W  = 9;
  localparam int DUTY_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int FOLD_W   = 7;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_QUARTER = 90;
  localparam int DUTY_MAX    = 255;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_WAVE = 1'b1;

  typedef enum logic [1:0] {
    CODE_NONE     = 2'd0,
    CODE_HIGH     = 2'd1,
    CODE_LOW      = 2'd2,
    CODE_HIGH_LOW = 2'd3
  } code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // one memory word per channel
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] err;
    code_t             pend;
  } chan_word_t;

  localparam logic [DUTY_W-1:0] QSINE_TAB [DEG_QUARTER+1] = '{
    8'd0,   8'd4,   8'd9,   8'd13,  8'd18,  8'd22,  8'd27,  8'd31,  8'd35,  8'd40,
    8'd44,  8'd49,  8'd53,  8'd57,  8'd62,  8'd66,  8'd70,  8'd75,  8'd79,  8'd83,
    8'd87,  8'd91,  8'd96,  8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124,
    8'd127, 8'd131, 8'd135, 8'd139, 8'd143, 8'd146, 8'd150, 8'd153, 8'd157, 8'd160,
    8'd164, 8'd167, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190, 8'd192,
    8'd195, 8'd198, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd214, 8'd216, 8'd219,
    8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231, 8'd233, 8'd235, 8'd236, 8'd238,
    8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250,
    8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255
  };

  // folded angle is 0..90 by construction
  function automatic logic [DUTY_W-1:0] quarter_sine(input logic [FOLD_W-1:0] a);
    logic [DUTY_W-1:0] v;
    v = '0;
    if (a <= FOLD_W'(DEG_QUARTER)) begin
      v = QSINE_TAB[a];
    end
    return v;
  endfunction

endpackage

@@ design/sine_wave_led_dither_pwm.sv @@
// top level of the eight-channel sine wave led driver with dithered pwm
// depends on swld_pkg, swld_chan_update and sine_wave_led_dither_pwm_macros.svh
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_mode, in_pot_sample
//   out_     output     out_valid / out_ready out_pin_levels
//
// after its transfer an item makes one pass over the channels before its result;
// the per-channel state memory has one read and one write port, and the
// sequencer visits one channel per cycle, read in one cycle, updated and written back
// in the next. the memory is not cleared; a valid flop per entry, cleared by reset,
// makes an entry that was never written read as all zero. a result held by low
// out_ready does not stop the next transfer; that item waits in its last state.
`include "sine_wave_led_dither_pwm_macros.svh"

module sine_wave_led_dither_pwm
  import swld_pkg::*;
#(
  parameter int CHANNELS = 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [POT_W-1:0]   in_pot_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] out_pin_levels
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(CHANNELS);
  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(CHANNELS - 1);
  localparam logic [ANGLE_W-1:0] PHASE_LAST = ANGLE_W'(DEG_FULL - 1);

  state_t state_r, state_nxt;

  // wave position
  logic [ANGLE_W-1:0]  phase_r;
  logic [ANGLE_W-1:0]  phase_inc;
  logic [ANGLE_W-1:0]  angle_r;
  logic [ANGLE_W-1:0]  angle_nxt;
  logic [ANGLE_W:0]    angle_sum;
  logic [SPREAD_W-1:0] spread_r;
  logic                mode_r;

  // sequencer and memory ports
  logic [CNT_W-1:0]    iss_cnt_r;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                proc_vld_r;
  logic [IDX_W-1:0]    proc_idx_r;
  logic                proc_last;
  chan_word_t          mem [CHANNELS];
  chan_word_t          rd_word_r;
  chan_word_t          cur_word;
  chan_word_t          wr_word;
  logic [CHANNELS-1:0] vld_r;
  logic                lvl;

  // pin levels
  logic [LEVEL_W-1:0]  levels_acc_r;
  logic [LEVEL_W-1:0]  levels_acc_nxt;
  logic [LEVEL_W-1:0]  last_levels_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_pin_levels_r;
  logic                out_free;
  logic                in_fire;

  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_pin_levels_r;

  // control sequence: idle, one pass over the channels, result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (proc_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // phase steps by one degree per wave step, wrapping at 360
  assign phase_inc = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;

  // channel angle advances by the spread, one compare-subtract keeps it below 360
  assign angle_sum = (ANGLE_W+1)'(angle_r) + (ANGLE_W+1)'(spread_r);
  assign angle_nxt = (angle_sum >= (ANGLE_W+1)'(DEG_FULL))
                   ? ANGLE_W'(angle_sum - (ANGLE_W+1)'(DEG_FULL))
                   : ANGLE_W'(angle_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ANGLE_W'(1);
    end else if (in_fire && in_mode == MODE_WAVE) begin
      phase_r <= phase_inc;
    end
  end

  // item payload; angle starts at the new phase for channel 0
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r   <= in_mode;
      spread_r <= in_pot_sample[POT_W-1:POT_W-SPREAD_W];
      angle_r  <= phase_inc;
    end else if (proc_vld_r) begin
      angle_r  <= angle_nxt;
    end
  end

  // read issue: one channel per cycle
  assign rd_en     = (state_r == ST_RUN) && (iss_cnt_r != CNT_LAST);
  assign rd_addr   = iss_cnt_r[IDX_W-1:0];
  assign proc_last = proc_vld_r && (proc_idx_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r  <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= rd_en;
      if (in_fire) begin
        iss_cnt_r <= '0;
      end else if (rd_en) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      proc_idx_r <= rd_addr;
    end
  end

  // state memory: registered read, write-back in the following cycle at another entry
  always_ff @(posedge clk) begin
    if (proc_vld_r) begin
      mem[proc_idx_r] <= wr_word;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (proc_vld_r) begin
      vld_r[proc_idx_r] <= 1'b1;
    end
  end

  // an entry never written holds reset state: zero duty, error and code
  assign cur_word = vld_r[proc_idx_r] ? rd_word_r : '0;

  swld_chan_update u_chan (
    .is_wave (mode_r == MODE_WAVE),
    .angle   (angle_r),
    .word_i  (cur_word),
    .word_o  (wr_word),
    .level   (lvl)
  );

  // channels past the pin width fall off the shift
  assign levels_acc_nxt = levels_acc_r | (LEVEL_W'(lvl) << proc_idx_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      levels_acc_r <= '0;
    end else if (proc_vld_r) begin
      levels_acc_r <= levels_acc_nxt;
    end
  end

  // wave steps repeat the levels of the last tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_levels_r <= '0;
    end else if (proc_last && mode_r == MODE_TICK) begin
      last_levels_r <= levels_acc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_pin_levels_r <= last_levels_r;
    end
  end

  `SWLD_ASSERT_ALWAYS(a_phase_range, phase_r <= PHASE_LAST, "phase left 0..359")
  `SWLD_ASSERT_IMPL(a_angle_range, proc_vld_r && mode_r == MODE_WAVE, angle_r <= PHASE_LAST, "channel angle left 0..359")
  `SWLD_ASSERT_IMPL(a_rw_collide, rd_en && proc_vld_r, rd_addr != proc_idx_r, "read and write-back hit the same entry")
  `SWLD_ASSERT_IMPL(a_proc_in_run, state_r != ST_RUN, !proc_vld_r && !rd_en, "memory access outside a channel pass")
  `SWLD_ASSERT_IMPL(a_tick_pend, proc_vld_r && mode_r == MODE_TICK, wr_word.pend == CODE_NONE || wr_word.pend == CODE_LOW, "tick left a high code pending")

endmodule

@@ design/swld_chan_update.sv @@
// per-channel update of the led dither pwm block: sine duty or bresenham dither
// depends on swld_pkg
module swld_chan_update
  import swld_pkg::*;
(
  input  logic               is_wave,
  input  logic [ANGLE_W-1:0] angle,
  input  chan_word_t         word_i,
  output chan_word_t         word_o,
  output logic               level
);

  logic [ANGLE_W-2:0] half_ang;
  logic [FOLD_W-1:0]  fold_ang;
  logic [DUTY_W-1:0]  on_w;
  logic [DUTY_W-1:0]  off_w;
  logic [DUTY_W-1:0]  sum;
  logic [DUTY_W-1:0]  err_nxt;
  code_t              code;

  // fold 0..359 down to 0..90
  always_comb begin
    if (angle >= ANGLE_W'(DEG_HALF)) begin
      half_ang = (ANGLE_W-1)'(angle - ANGLE_W'(DEG_HALF));
    end else begin
      half_ang = angle[ANGLE_W-2:0];
    end
    if (half_ang > (ANGLE_W-1)'(DEG_QUARTER)) begin
      fold_ang = FOLD_W'((ANGLE_W-1)'(DEG_HALF) - half_ang);
    end else begin
      fold_ang = FOLD_W'(half_ang);
    end
  end

  // dither: draw a fresh code only when none is pending
  always_comb begin
    on_w    = word_i.duty;
    off_w   = DUTY_W'(DUTY_MAX) - on_w;
    sum     = '0;
    err_nxt = word_i.err;
    code    = word_i.pend;
    if (word_i.pend == CODE_NONE) begin
      if (on_w == '0) begin
        code = CODE_HIGH;
      end else if (off_w == '0) begin
        code = CODE_LOW;
      end else if (on_w > off_w) begin
        sum = word_i.err + off_w;
        if (sum >= on_w) begin
          err_nxt = sum - on_w;
          code    = CODE_HIGH_LOW;
        end else begin
          err_nxt = sum;
          code    = CODE_LOW;
        end
      end else begin
        sum = word_i.err + on_w;
        if (sum >= off_w) begin
          err_nxt = sum - off_w;
          code    = CODE_HIGH_LOW;
        end else begin
          err_nxt = sum;
          code    = CODE_HIGH;
        end
      end
    end
  end

  always_comb begin
    word_o = word_i;
    level  = 1'b0;
    if (is_wave) begin
      word_o.duty = quarter_sine(fold_ang);
    end else begin
      word_o.err = err_nxt;
      level      = (code == CODE_HIGH) || (code == CODE_HIGH_LOW);
      case (code)
        CODE_HIGH_LOW: word_o.pend = CODE_LOW;
        default:       word_o.pend = CODE_NONE;
      endcase
    end
  end

endmodule

@@ tb/sine_wave_led_dither_pwm_test.sv @@
// self-checking testbench for the eight-channel sine wave led driver with dithered pwm
// depends on swld_pkg and the sine_wave_led_dither_pwm top level; nothing else
// a directed table runs first, then random wave steps and pwm ticks under varying back-pressure
module sine_wave_led_dither_pwm_test;
  import swld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CHAN     = 8;
  localparam int CLK_HALF   = 6;
  localparam int LATENCY    = N_CHAN + 3;
  localparam int PHASE_ITEMS = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_ITEMS = 14;
  // watchdog limit for the whole run, in nanoseconds
  localparam int RUN_LIMIT_NS = 9_000_000;

  // one row of the directed table; has_lv marks a level pattern typed in by hand
  typedef struct packed {
    logic              mode;
    logic [POT_W-1:0]  pot;
    logic              has_lv;
    logic [LEVEL_W-1:0] lv;
  } stim_row_t;

  localparam int N_ROWS = 20;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // zero duty after reset: every channel draws a high code
    '{MODE_TICK, 10'd0,    1'b1, 8'hFF},
    '{MODE_TICK, 10'd1023, 1'b1, 8'hFF},
    // wave step only repeats the last tick's levels
    '{MODE_WAVE, 10'd0,    1'b1, 8'hFF},
    '{MODE_TICK, 10'd341,  1'b0, 8'h00},
    '{MODE_TICK, 10'd682,  1'b0, 8'h00},
    '{MODE_TICK, 10'd0,    1'b0, 8'h00},
    // spread of 88 puts channel 1 on the crest: full duty, low codes only
    '{MODE_WAVE, 10'd352,  1'b0, 8'h00},
    '{MODE_TICK, 10'd1023, 1'b0, 8'h00},
    '{MODE_TICK, 10'd0,    1'b0, 8'h00},
    '{MODE_TICK, 10'd341,  1'b0, 8'h00},
    '{MODE_TICK, 10'd682,  1'b0, 8'h00},
    '{MODE_TICK, 10'd5,    1'b0, 8'h00},
    // widest spread between neighbours
    '{MODE_WAVE, 10'd1023, 1'b0, 8'h00},
    '{MODE_TICK, 10'd0,    1'b0, 8'h00},
    '{MODE_TICK, 10'd0,    1'b0, 8'h00},
    '{MODE_TICK, 10'd0,    1'b0, 8'h00},
    '{MODE_WAVE, 10'd360,  1'b0, 8'h00},
    '{MODE_TICK, 10'd682,  1'b0, 8'h00},
    '{MODE_TICK, 10'd341,  1'b0, 8'h00},
    '{MODE_TICK, 10'd1023, 1'b0, 8'h00}
  };

  // dut ports; the inputs are all known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = MODE_TICK;
  logic [POT_W-1:0]   in_pot_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] out_pin_levels;

  sine_wave_led_dither_pwm #(
    .CHANNELS(N_CHAN)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_pot_sample (in_pot_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pin_levels(out_pin_levels)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state: travelling wave phase and per-channel dither state
  logic [ANGLE_W-1:0] led_phase;
  logic [DUTY_W-1:0]  chan_duty [N_CHAN];
  logic [DUTY_W-1:0]  chan_err  [N_CHAN];
  code_t              chan_pend [N_CHAN];
  logic [LEVEL_W-1:0] led_levels;

  // pin patterns still owed by the block, oldest first
  logic [LEVEL_W-1:0] expected_levels [$];
  int                 errors = 0;

  // back-pressure knobs: percent of cycles spent idle or stalled, and a counted stall
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int stall_left     = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_led_state();
    led_phase  = ANGLE_W'(1);
    led_levels = '0;
    for (int k = 0; k < N_CHAN; k++) begin
      chan_duty[k] = '0;
      chan_err[k]  = '0;
      chan_pend[k] = CODE_NONE;
    end
  endfunction

  // sine magnitude at any angle, folded onto the quarter wave
  function automatic logic [DUTY_W-1:0] wave_duty(input int deg);
    int a;
    a = (deg % DEG_FULL) % DEG_HALF;
    if (a > DEG_QUARTER) begin
      a = DEG_HALF - a;
    end
    return QSINE_TAB[a];
  endfunction

  // bresenham step: on-weight is the duty, off-weight its complement
  function automatic code_t dither_code(input int k);
    logic [DUTY_W-1:0] on_w;
    logic [DUTY_W-1:0] off_w;
    logic [DUTY_W-1:0] acc;
    on_w  = chan_duty[k];
    off_w = DUTY_W'(DUTY_MAX) - on_w;
    // zero and full duty leave the error alone
    if (on_w == '0) begin
      return CODE_HIGH;
    end
    if (off_w == '0) begin
      return CODE_LOW;
    end
    if (on_w == off_w) begin
      return CODE_HIGH_LOW;
    end
    acc = chan_err[k];
    if (on_w > off_w) begin
      acc = acc + off_w;  // wraps at 8 bits
      if (acc >= on_w) begin
        chan_err[k] = acc - on_w;
        return CODE_HIGH_LOW;
      end
      chan_err[k] = acc;
      return CODE_LOW;
    end
    acc = acc + on_w;
    if (acc >= off_w) begin
      chan_err[k] = acc - off_w;
      return CODE_HIGH_LOW;
    end
    chan_err[k] = acc;
    return CODE_HIGH;
  endfunction

  // advances the predictor by one item and returns the pin pattern it owes
  function automatic logic [LEVEL_W-1:0] predict_pin_levels(input logic mode,
                                                            input logic [POT_W-1:0] pot);
    int                 spread;
    int                 deg;
    logic [1:0]         code;
    logic [LEVEL_W-1:0] lv;
    if (mode == MODE_WAVE) begin
      spread = int'(pot >> 2);
      deg = int'(led_phase) + 1;
      if (deg >= DEG_FULL) begin
        deg = deg - DEG_FULL;
      end
      led_phase = ANGLE_W'(deg);
      for (int k = 0; k < N_CHAN; k++) begin
        chan_duty[k] = wave_duty(deg + k * spread);
      end
    end else begin
      lv = '0;
      for (int k = 0; k < N_CHAN; k++) begin
        code = chan_pend[k];
        if (code == CODE_NONE) begin
          code = dither_code(k);
        end
        if (code[0]) begin
          if (k < LEVEL_W) begin
            lv[k] = 1'b1;
          end
          code = code - 2'd1;
        end else if (code[1]) begin
          code = code - 2'd2;
        end
        chan_pend[k] = code_t'(code);
      end
      led_levels = lv;
    end
    return led_levels;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: random idle gaps, then hold the item until its transfer
  // ---------------------------------------------------------------------------

  task automatic offer_item(input logic mode, input logic [POT_W-1:0] pot,
                            input logic has_lv, input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] want;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_pot_sample <= pot;
    // in_valid is high at every edge seen here, so in_ready alone decides
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
    want = predict_pin_levels(mode, pot);
    expected_levels.push_back(has_lv ? lv : want);
  endtask

  // random item, weighted toward ticks so codes run over several ticks per wave step
  task automatic offer_random_item();
    logic             mode;
    logic [POT_W-1:0] pot;
    int               pick;
    mode = ($urandom_range(3) == 0) ? MODE_WAVE : MODE_TICK;
    pick = $urandom_range(9);
    if (pick == 0) begin
      pot = '0;
    end else if (pick == 1) begin
      pot = '1;
    end else if (pick == 2) begin
      // spread close to a quarter turn lands some channels on the crest
      pot = POT_W'($urandom_range(86, 94) * 4 + $urandom_range(3));
    end else begin
      pot = POT_W'($urandom_range(1023));
    end
    offer_item(mode, pot, 1'b0, '0);
  endtask

  // pause the sender until every owed pattern has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, or a counted hold-off when requested
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // compare each result transfer with the oldest owed pattern
  logic [LEVEL_W-1:0] owed;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pin_levels %h",
                 $realtime, out_pin_levels);
        errors++;
      end else begin
        owed = expected_levels.pop_front();
        if (out_pin_levels !== owed) begin
          $display("%0t: pin_levels mismatch, expected %h, actual %h",
                   $realtime, owed, out_pin_levels);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int idle_set [4];
    int stall_set [4];
    clear_led_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: reset state, field extremes, zero and full duty
    for (int r = 0; r < N_ROWS; r++) begin
      offer_item(DIRECTED[r].mode, DIRECTED[r].pot, DIRECTED[r].has_lv, DIRECTED[r].lv);
    end
    drain_results();

    // idling phases: none, sender idle, receiver stalling, both
    idle_set  = '{0, 82, 0, 34};
    stall_set = '{0, 0, 82, 34};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_set[p];
      sink_stall_pct = stall_set[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer_random_item();
      end
      if (p == 0) begin
        // long receiver hold-off while the sender keeps pushing, so the block backs up
        @(negedge clk);
        stall_left = HOLD_CYCLES;
        @(posedge clk);
        for (int i = 0; i < BURST_ITEMS; i++) begin
          offer_random_item();
        end
        drain_results();
      end
    end

    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sine_wave_led_dither_pwm.f @@
+incdir+design
design/swld_pkg.sv
design/swld_chan_update.sv
design/sine_wave_led_dither_pwm.sv
tb/sine_wave_led_dither_pwm_test.sv
